// File: src/btmx_pkg.sv
// Shared types and constants for the binary trie max-xor block.
// No dependencies; imported by every module of the block but btmx_ram.
package btmx_pkg;

    localparam int KEY_W          = 20;     // key port width
    localparam int XOR_W          = 20;     // max_xor port width
    localparam int CNT_W          = 16;     // node count width
    localparam int DEF_KEY_BITS   = 20;
    localparam int DEF_NODE_LIMIT = 65536;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_ERASE  = 2'd1;
    localparam t_mode MODE_QUERY  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_FULL   = 2'd2;
    localparam t_status ST_ABSENT = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // control that rides along with the lookup wave
    typedef struct packed {
        logic  valid;
        t_mode mode;
    } t_wave_ctl;

    // commit command broadcast to all level cells
    typedef struct packed {
        logic en;
        logic ins;  // 1: insert update, 0: erase update
    } t_wr_cmd;

endpackage

// File: src/binary_trie_max_xor.sv
// Binary trie max-xor engine: multiset of KEY_BITS-wide keys with insert, erase and
// query of the largest xor against any stored key. The trie is split by depth into a
// chain of KEY_BITS level cells, each with its own node memory; the root node lives in
// flip-flops here. An operation enters, a lookup wave steps down one level per cycle
// (one registered memory read per level), then a commit updates every level at
// once and loads the result register. The block therefore takes one item at a time: the
// next input transfer waits for the commit, which waits while a stalled result is held.
// Failing operations (full pool, count limit, absent key) change nothing. Only the root
// is cleared by reset; other nodes are written when allocated, so no clearing pass runs.
// Depends on btmx_pkg, btmx_cell and btmx_ram.
module binary_trie_max_xor import btmx_pkg::*; #(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int NODE_LIMIT = DEF_NODE_LIMIT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_mode,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_stall,
    output logic             o_valid,
    output logic [XOR_W-1:0] o_max_xor,
    output logic [1:0]       o_status,
    input  logic             i_stall
);

    localparam int KB  = KEY_BITS;
    localparam int NL  = NODE_LIMIT;
    localparam int IW  = $clog2(NL);
    localparam int NFW = $clog2(NL+1);
    localparam int LW  = $clog2(KB+2);
    localparam int SW  = NFW + 7;

    // lookup wave between cells; index 0 is driven from the root
    t_wave_ctl         w_ctl    [KB+1];
    logic [KB-1:0]     w_key    [KB+1];
    logic [KB-1:0]     w_acc    [KB+1];
    logic [LW-1:0]     w_nexist [KB+1];
    logic [IW-1:0]     w_idx0   [KB+1];
    logic [IW-1:0]     w_idx1   [KB+1];
    logic [CNT_W-1:0]  w_cnt    [KB+1];

    t_state            r_state, n_state;
    logic              accept, fire;

    logic [KB-1:0]     key_int;

    // root node and pool allocator
    logic [IW-1:0]     r_root_l0, r_root_l1;
    logic [CNT_W-1:0]  r_root_cnt;
    logic [NFW-1:0]    r_nf;

    // end-of-walk summary
    t_mode             r_fin_mode;
    logic [KB-1:0]     r_fin_key;
    logic [KB-1:0]     r_fin_acc;
    logic [LW-1:0]     r_fin_nexist;
    logic [CNT_W-1:0]  r_fin_cnt;

    logic              r_out_valid;
    logic [XOR_W-1:0]  r_max_xor;
    t_status           r_status;

    t_status           c_status;
    logic [XOR_W-1:0]  c_acc20, c_max;
    logic              c_ok_ins, c_ok_era;
    logic [SW-1:0]     c_need;
    logic [LW-1:0]     c_first;
    t_wr_cmd           wr_cmd;

    // map the key port onto KEY_BITS bits and the xor onto the result port
    for (genvar gi = 0; gi < KB; gi++) begin : g_key
        if (gi < KEY_W) begin : g_in
            assign key_int[gi] = i_key[gi];
        end else begin : g_zero
            assign key_int[gi] = 1'b0;
        end
    end

    for (genvar gi = 0; gi < XOR_W; gi++) begin : g_xor
        if (gi < KB) begin : g_in
            assign c_acc20[gi] = r_fin_acc[gi];
        end else begin : g_zero
            assign c_acc20[gi] = 1'b0;
        end
    end

    // root stage: the wave starts on the input transfer with the root links
    assign w_ctl[0]    = '{valid: accept, mode: t_mode'(i_mode)};
    assign w_key[0]    = key_int;
    assign w_acc[0]    = '0;
    assign w_nexist[0] = '0;
    assign w_idx0[0]   = r_root_l0;
    assign w_idx1[0]   = r_root_l1;
    assign w_cnt[0]    = r_root_cnt;

    for (genvar gl = 1; gl <= KB; gl++) begin : g_level
        btmx_cell #(
            .KB    (KB),
            .NL    (NL),
            .LEVEL (gl)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[gl-1]),
            .i_key    (w_key[gl-1]),
            .i_acc    (w_acc[gl-1]),
            .i_nexist (w_nexist[gl-1]),
            .i_idx0   (w_idx0[gl-1]),
            .i_idx1   (w_idx1[gl-1]),
            .o_ctl    (w_ctl[gl]),
            .o_key    (w_key[gl]),
            .o_acc    (w_acc[gl]),
            .o_nexist (w_nexist[gl]),
            .o_idx0   (w_idx0[gl]),
            .o_idx1   (w_idx1[gl]),
            .o_cnt    (w_cnt[gl]),
            .i_wr     (wr_cmd),
            .i_nf     (r_nf),
            .i_first  (c_first)
        );
    end

    // control FSM: idle -> walk down the levels -> commit and publish
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_ctl[KB].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        accept  = 1'b0;
        fire    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                accept  = i_valid;
            end
            S_DONE: begin
                // commit only once the result register can take the result
                fire = !r_out_valid || !i_stall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WALK) && w_ctl[KB].valid) begin
            r_fin_mode   <= w_ctl[KB].mode;
            r_fin_key    <= w_key[KB];
            r_fin_acc    <= w_acc[KB];
            r_fin_nexist <= w_nexist[KB];
            r_fin_cnt    <= w_cnt[KB];
        end
    end

    // outcome of the operation from the walk summary
    always_comb begin
        c_status = ST_OK;
        c_max    = '0;
        c_ok_ins = 1'b0;
        c_ok_era = 1'b0;
        c_need   = SW'(r_nf) + (SW'(KB) - SW'(r_fin_nexist));
        c_first  = r_fin_nexist + LW'(1);
        case (r_fin_mode)
            MODE_INSERT: begin
                if ((r_root_cnt == CNT_MAX) || (c_need > SW'(NL))) begin
                    c_status = ST_FULL;
                end else begin
                    c_ok_ins = 1'b1;
                end
            end
            MODE_ERASE: begin
                if ((r_fin_nexist != LW'(KB)) || (r_fin_cnt == '0)) begin
                    c_status = ST_ABSENT;
                end else begin
                    c_ok_era = 1'b1;
                end
            end
            MODE_QUERY: begin
                if (r_root_cnt == '0) begin
                    c_status = ST_EMPTY;
                end else begin
                    c_max = c_acc20;
                end
            end
            default: ;
        endcase
        wr_cmd.en  = fire && (c_ok_ins || c_ok_era);
        wr_cmd.ins = c_ok_ins;
    end

    // root node and allocator update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_l0  <= '0;
            r_root_l1  <= '0;
            r_root_cnt <= '0;
            r_nf       <= NFW'(1);
        end else if (wr_cmd.en) begin
            if (wr_cmd.ins) begin
                r_root_cnt <= r_root_cnt + CNT_W'(1);
                r_nf       <= c_need[NFW-1:0];
                if (r_fin_nexist == '0) begin
                    if (r_fin_key[KB-1]) begin
                        r_root_l1 <= r_nf[IW-1:0];
                    end else begin
                        r_root_l0 <= r_nf[IW-1:0];
                    end
                end
            end else begin
                r_root_cnt <= r_root_cnt - CNT_W'(1);
            end
        end
    end

    // result register: holds while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_max_xor <= c_max;
            r_status  <= c_status;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_max_xor = r_max_xor;
    assign o_status  = r_status;

endmodule

// File: src/btmx_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]                    o_rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                    o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: src/btmx_cell.sv
// One trie level: node memory for that depth, path choice, commit update.
// Depends on btmx_pkg and btmx_ram.
module btmx_cell import btmx_pkg::*; #(
    parameter int KB    = DEF_KEY_BITS,
    parameter int NL    = DEF_NODE_LIMIT,
    parameter int LEVEL = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_wave_ctl                     i_ctl,
    input  logic [KB-1:0]                 i_key,
    input  logic [KB-1:0]                 i_acc,
    input  logic [$clog2(KB+2)-1:0]       i_nexist,
    input  logic [$clog2(NL)-1:0]         i_idx0,
    input  logic [$clog2(NL)-1:0]         i_idx1,
    output t_wave_ctl                     o_ctl,
    output logic [KB-1:0]                 o_key,
    output logic [KB-1:0]                 o_acc,
    output logic [$clog2(KB+2)-1:0]       o_nexist,
    output logic [$clog2(NL)-1:0]         o_idx0,
    output logic [$clog2(NL)-1:0]         o_idx1,
    output logic [CNT_W-1:0]              o_cnt,
    input  t_wr_cmd                       i_wr,
    input  logic [$clog2(NL+1)-1:0]       i_nf,
    input  logic [$clog2(KB+2)-1:0]       i_first
);

    localparam int IW        = $clog2(NL);
    localparam int NFW       = $clog2(NL+1);
    localparam int LW        = $clog2(KB+2);
    localparam int SW        = NFW + 7;
    localparam int EW        = 2*IW + CNT_W;
    localparam int BPOS      = KB - LEVEL;
    localparam bit HAS_CHILD = (LEVEL < KB);
    localparam int NB_POS    = HAS_CHILD ? (KB - 1 - LEVEL) : 0;

    t_wave_ctl          r_ctl;
    logic [KB-1:0]      r_key;
    logic [KB-1:0]      r_acc;
    logic [LW-1:0]      r_nexist;
    logic [IW-1:0]      r_idx0, r_idx1;

    logic [EW-1:0]      rd0, rd1;
    logic [IW-1:0]      l0_0, l1_0, l0_1, l1_1;
    logic [CNT_W-1:0]   cnt_0, cnt_1;

    logic               bit_k, has0, has1, opp_has, take_opp, sel, c_has;
    logic [CNT_W-1:0]   opp_cnt, c_cnt;
    logic [IW-1:0]      c_idx, c_l0, c_l1;

    logic               r_own_has, r_nb;
    logic [IW-1:0]      r_own_idx, r_own_l0, r_own_l1;
    logic [CNT_W-1:0]   r_own_cnt;

    logic               w_we;
    logic [IW-1:0]      w_addr, w_l0, w_l1;
    logic [CNT_W-1:0]   w_cnt;
    logic [SW-1:0]      new_sum;
    logic [IW-1:0]      new_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= i_key;
        r_acc    <= i_acc;
        r_nexist <= i_nexist;
        r_idx0   <= i_idx0;
        r_idx1   <= i_idx1;
    end

    btmx_ram #(
        .WIDTH (EW),
        .DEPTH (NL)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_addr),
        .i_wdata   ({w_l1, w_l0, w_cnt}),
        .i_raddr_a (i_idx0),
        .o_rdata_a (rd0),
        .i_raddr_b (i_idx1),
        .o_rdata_b (rd1)
    );

    assign {l1_0, l0_0, cnt_0} = rd0;
    assign {l1_1, l0_1, cnt_1} = rd1;

    // pick the child: key bit for insert/erase, opposite bit for query when populated
    always_comb begin
        bit_k    = r_key[BPOS];
        has0     = (r_idx0 != '0);
        has1     = (r_idx1 != '0);
        opp_has  = bit_k ? has0 : has1;
        opp_cnt  = bit_k ? cnt_0 : cnt_1;
        take_opp = (r_ctl.mode == MODE_QUERY) && opp_has && (opp_cnt != '0);
        sel      = take_opp ? ~bit_k : bit_k;
        c_idx    = sel ? r_idx1 : r_idx0;
        c_has    = sel ? has1 : has0;
        c_l0     = c_has ? (sel ? l0_1 : l0_0) : '0;
        c_l1     = c_has ? (sel ? l1_1 : l1_0) : '0;
        c_cnt    = c_has ? (sel ? cnt_1 : cnt_0) : '0;
    end

    always_comb begin
        o_ctl         = r_ctl;
        o_key         = r_key;
        o_acc         = r_acc;
        o_acc[BPOS]   = r_acc[BPOS] | take_opp;
        o_nexist      = r_nexist + LW'(c_has);
        o_idx0        = c_l0;
        o_idx1        = c_l1;
        o_cnt         = c_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            r_own_has <= c_has;
            r_own_idx <= c_idx;
            r_own_l0  <= c_l0;
            r_own_l1  <= c_l1;
            r_own_cnt <= c_cnt;
            r_nb      <= r_key[NB_POS];
        end
    end

    // commit: new nodes take consecutive pool indices from the first missing level
    always_comb begin
        new_sum  = SW'(i_nf) + SW'(LEVEL) - SW'(i_first);
        new_addr = new_sum[IW-1:0];
        w_we     = 1'b0;
        w_addr   = r_own_idx;
        w_l0     = r_own_l0;
        w_l1     = r_own_l1;
        w_cnt    = r_own_cnt;
        if (i_wr.en) begin
            w_we = 1'b1;
            if (i_wr.ins) begin
                if (r_own_has) begin
                    w_cnt = r_own_cnt + CNT_W'(1);
                    if (HAS_CHILD && (i_first == LW'(LEVEL + 1))) begin
                        if (r_nb) begin
                            w_l1 = i_nf[IW-1:0];
                        end else begin
                            w_l0 = i_nf[IW-1:0];
                        end
                    end
                end else begin
                    w_addr = new_addr;
                    w_cnt  = CNT_W'(1);
                    w_l0   = '0;
                    w_l1   = '0;
                    if (HAS_CHILD) begin
                        if (r_nb) begin
                            w_l1 = new_addr + IW'(1);
                        end else begin
                            w_l0 = new_addr + IW'(1);
                        end
                    end
                end
            end else begin
                w_cnt = r_own_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// File: src/btmx_checker.sv
// Port-level checks for binary_trie_max_xor, bound to the top level.
// Depends on btmx_pkg.
module btmx_checker import btmx_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic [XOR_W-1:0] o_max_xor,
    input logic [1:0]       o_status,
    input logic             i_stall
);

    // one item at a time: an input transfer closes the input side
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open right after a transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_max_xor) && $stable(o_status)))
        else $error("stalled result changed");

    // a failed operation carries a zero xor
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_max_xor == '0))
        else $error("failed operation with nonzero max_xor");

    // a new result only appears after the block was busy
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a preceding walk");

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for binary_trie_max_xor: insert, erase and max-xor query traffic.
// Depends on btmx_pkg and the binary_trie_max_xor RTL; carries its own trie predictor.
`timescale 1ns / 100ps

module testbench import btmx_pkg::*; ();

    localparam int    NODES     = DEF_NODE_LIMIT;
    localparam int    TAIL_WAIT = DEF_KEY_BITS + 30;   // drain after last result
    localparam int    HOLD_LEN  = 400;                 // long receiver hold-off
    localparam longint CYCLE_LIMIT = 3000000;
    localparam t_mode MODE_NONE = 2'd3;                // unused op code, does nothing

    typedef struct {
        t_mode            mode;
        logic [KEY_W-1:0] key;
    } t_op;

    typedef struct {
        logic [XOR_W-1:0] max_xor;
        t_status          status;
    } t_answer;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic [1:0]       i_mode;
    logic [KEY_W-1:0] i_key;
    logic             o_stall;
    logic             o_valid;
    logic [XOR_W-1:0] o_max_xor;
    logic [1:0]       o_status;
    logic             i_stall;

    binary_trie_max_xor uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_mode    (i_mode),
        .i_key     (i_key),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_max_xor (o_max_xor),
        .o_status  (o_status),
        .i_stall   (i_stall)
    );

    // ------------------------------------------------------------------
    // Trie shadow: same pool layout as the block, node 0 is the root.
    // ------------------------------------------------------------------
    int unsigned zero_kid [NODES];
    int unsigned one_kid  [NODES];
    int unsigned key_cnt  [NODES];
    int unsigned alloc_ptr;

    t_op     op_queue [$];      // items waiting to be offered
    t_answer answers  [$];      // predicted results in order
    logic [KEY_W-1:0] live_keys [$];

    int  errors;
    int  n_full, n_empty, n_absent, n_hits, n_checked;
    longint cycles;
    logic hold_req, hold_busy;

    function automatic int unsigned kid(int unsigned node, bit b);
        return b ? one_kid[node] : zero_kid[node];
    endfunction

    // Compute the answer for one transfer and update the shadow trie.
    function automatic t_answer trie_apply(t_mode mode, logic [KEY_W-1:0] key);
        t_answer     a;
        int unsigned cur, nx, lack;
        bit          b;
        a.max_xor = '0;
        a.status  = ST_OK;
        cur  = 0;
        lack = 0;
        case (mode)
            MODE_INSERT: begin
                if (key_cnt[0] >= CNT_MAX) begin
                    a.status = ST_FULL;
                    return a;
                end
                for (int i = KEY_W - 1; i >= 0; i--) begin
                    nx = kid(cur, key[i]);
                    if (nx == 0) begin
                        lack = i + 1;
                        break;
                    end
                    cur = nx;
                end
                if (alloc_ptr + lack > NODES) begin
                    a.status = ST_FULL;
                    return a;
                end
                cur = 0;
                for (int i = KEY_W - 1; i >= 0; i--) begin
                    key_cnt[cur]++;
                    nx = kid(cur, key[i]);
                    if (nx == 0) begin
                        nx = alloc_ptr++;
                        zero_kid[nx] = 0;
                        one_kid[nx]  = 0;
                        key_cnt[nx]  = 0;
                        if (key[i]) one_kid[cur] = nx;
                        else        zero_kid[cur] = nx;
                    end
                    cur = nx;
                end
                key_cnt[cur]++;
            end
            MODE_ERASE: begin
                for (int i = KEY_W - 1; i >= 0; i--) begin
                    cur = kid(cur, key[i]);
                    if (cur == 0) begin
                        a.status = ST_ABSENT;
                        return a;
                    end
                end
                if (key_cnt[cur] == 0) begin
                    a.status = ST_ABSENT;
                    return a;
                end
                cur = 0;
                for (int i = KEY_W - 1; i >= 0; i--) begin
                    key_cnt[cur]--;
                    cur = kid(cur, key[i]);
                end
                key_cnt[cur]--;
            end
            MODE_QUERY: begin
                if (key_cnt[0] == 0) begin
                    a.status = ST_EMPTY;
                    return a;
                end
                for (int i = KEY_W - 1; i >= 0; i--) begin
                    b  = key[i];
                    nx = kid(cur, !b);
                    if (nx != 0 && key_cnt[nx] > 0) begin
                        a.max_xor[i] = 1'b1;
                        cur = nx;
                    end else begin
                        cur = kid(cur, b);
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // Clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, answers.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps between them.
    // Prediction happens at the edge where the transfer is taken.
    // ------------------------------------------------------------------
    int burst_left, gap_left;
    t_op next_op;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                answers.push_back(trie_apply(t_mode'(i_mode), i_key));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    next_op = op_queue.pop_front();
                    i_valid <= 1'b1;
                    i_mode  <= next_op.mode;
                    i_key   <= next_op.key;
                    if (burst_left <= 1) begin
                        // new burst; a third of them run with no gap at all
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: phases of none / light / heavy stalling, plus a
    // long hold-off on request that lets the block back up.
    // ------------------------------------------------------------------
    int stall_mode, stall_phase, hold_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_mode  <= 0;
            stall_phase <= 0;
            hold_cnt    <= 0;
            hold_busy   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= (hold_cnt > 1);
            if (hold_cnt == 1) hold_busy <= 1'b0;
        end else if (hold_req && !hold_busy) begin
            hold_cnt  <= HOLD_LEN;
            hold_busy <= 1'b1;
            i_stall   <= 1'b1;
        end else begin
            if (stall_phase == 0) begin
                stall_mode  <= $urandom_range(0, 2);
                stall_phase <= $urandom_range(50, 500);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    t_answer want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers.size() == 0) begin
                $display("%0t: unexpected result max_xor=%h status=%0d",
                         $time, o_max_xor, o_status);
                errors <= errors + 1;
            end else begin
                want = answers.pop_front();
                n_checked <= n_checked + 1;
                if (o_max_xor !== want.max_xor) begin
                    $display("%0t: max_xor expected %h actual %h",
                             $time, want.max_xor, o_max_xor);
                    errors <= errors + 1;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors <= errors + 1;
                end
                case (want.status)
                    ST_FULL:   n_full   <= n_full + 1;
                    ST_EMPTY:  n_empty  <= n_empty + 1;
                    ST_ABSENT: n_absent <= n_absent + 1;
                    default:   if (want.max_xor != 0) n_hits <= n_hits + 1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_op(t_mode m, logic [KEY_W-1:0] k);
        t_op o;
        o.mode = m;
        o.key  = k;
        op_queue.push_back(o);
        if (m == MODE_INSERT) live_keys.push_back(k);
    endtask

    // wait until everything queued has gone through and come back
    task automatic drain();
        while (op_queue.size() > 0 || i_valid || answers.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'($urandom);
    endfunction

    // mixed traffic; erases mostly target keys that were inserted
    task automatic push_mix(int n);
        int unsigned r, idx;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                if (live_keys.size() > 0 && $urandom_range(0, 4) == 0)
                    push_op(MODE_INSERT, live_keys[$urandom_range(0, live_keys.size() - 1)]);
                else
                    push_op(MODE_INSERT, rand_key());
            end else if (r < 65) begin
                if (live_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
                    idx = $urandom_range(0, live_keys.size() - 1);
                    push_op(MODE_ERASE, live_keys[idx]);
                    live_keys.delete(idx);
                end else begin
                    push_op(MODE_ERASE, rand_key());
                end
            end else if (r < 96) begin
                push_op(MODE_QUERY, rand_key());
            end else begin
                push_op(MODE_NONE, rand_key());
            end
        end
    endtask

    initial begin
        errors    = 0;
        n_full    = 0;
        n_empty   = 0;
        n_absent  = 0;
        n_hits    = 0;
        n_checked = 0;
        cycles    = 0;
        hold_req  = 1'b0;
        i_valid   = 1'b0;
        i_mode    = MODE_INSERT;
        i_key     = '0;
        i_stall   = 1'b0;
        i_rst_n   = 1'b0;
        alloc_ptr = 1;
        zero_kid[0] = 0;
        one_kid[0]  = 0;
        key_cnt[0]  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty set, absent erase, unused op, key extremes, duplicates
        push_op(MODE_QUERY,  '0);
        push_op(MODE_ERASE,  '1);
        push_op(MODE_NONE,   20'h5A5A5);
        push_op(MODE_INSERT, '0);
        push_op(MODE_QUERY,  '0);
        push_op(MODE_QUERY,  '1);
        push_op(MODE_INSERT, '1);
        push_op(MODE_QUERY,  '0);
        push_op(MODE_QUERY,  20'h80000);
        push_op(MODE_INSERT, '1);
        push_op(MODE_ERASE,  '1);
        push_op(MODE_QUERY,  20'h00001);
        push_op(MODE_ERASE,  '1);
        push_op(MODE_ERASE,  '1);
        push_op(MODE_ERASE,  20'h00001);   // shares no leaf with stored keys
        push_op(MODE_INSERT, 20'hAAAAA);
        push_op(MODE_INSERT, 20'h55555);
        push_op(MODE_QUERY,  20'hAAAAA);
        push_op(MODE_ERASE,  '0);
        push_op(MODE_QUERY,  20'h55555);
        push_op(MODE_ERASE,  20'hAAAAA);
        push_op(MODE_ERASE,  20'h55555);
        push_op(MODE_QUERY,  20'h12345);
        live_keys.delete();
        drain();

        // Random traffic; sender pauses for a full drain after every fourth batch
        for (int b = 0; b < 18; b++) begin
            if (b == 5) begin
                // long hold-off while the sender keeps offering
                hold_req = 1'b1;
                push_mix(100);
                wait (hold_busy);
                hold_req = 1'b0;
            end else begin
                push_mix(100);
            end
            if (b % 4 == 3) drain();
        end
        drain();

        live_keys.delete();
        push_mix(100);
        drain();

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (answers.size() != 0) begin
            $display("%0d predicted results never arrived", answers.size());
            errors = errors + 1;
        end
        $display("checked %0d results over %0d cycles: %0d nonzero xor, %0d empty,",
                 n_checked, cycles, n_hits, n_empty);
        $display("%0d absent erase, %0d refused insert, %0d of %0d nodes allocated",
                 n_absent, n_full, alloc_ptr, NODES);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/btmx_pkg.sv
src/btmx_ram.sv
src/btmx_cell.sv
src/binary_trie_max_xor.sv
src/btmx_checker.sv
verif/testbench.sv
